### sv/nqf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nqf_pkg
// Shared types for the N-Queens first-solution finder: result codes,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package nqf_pkg;

    localparam int unsigned SIZE_W   = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FIELD_W  = 4;

    typedef enum logic [STATUS_W-1:0] {
        RES_SOLUTION = 2'd0,
        RES_NONE     = 2'd1,
        RES_INVALID  = 2'd2
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWEEP,
        ST_EMIT,
        ST_REPORT_NONE,
        ST_REPORT_BAD
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    start;     // latch size, clear masks and depth
        logic    place;     // put a queen at the current square, go one column deeper
        logic    next_row;  // try the next row in this column
        logic    pop;       // lift the queen of the previous column, resume after it
        logic    sweep;     // build the row-to-column table, one column a cycle
        logic    emit;      // load one solution row into the output register
        logic    report;    // load a single status beat into the output register
        t_result code;      // status code for report
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic size_bad;
        logic col_done;
        logic col_zero;
        logic r_lt_n;
        logic sq_free;
        logic row_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

### sv/n_queens_first_solution.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// n_queens_first_solution
// First N-Queens placement by depth-first backtracking, one row per beat.
//
// Input channel: i_valid / o_stall carry a board size. A beat is taken only
// while the block is idle; o_stall is high from the accepted beat until the
// last result of that request has been loaded into the output register.
// Output channel: o_valid / i_stall. For a solvable size N the block sends N
// beats, one per board row in ascending order, giving the queen's column;
// the final beat has o_last set. Sizes 2 and 3 give one "no solution" beat,
// sizes 0 and above MAX_SIZE one "invalid" beat.
// Timing: one search step per cycle (test one square, or place, or lift one
// queen), then a sweep that inverts the row stack into a row-to-column table,
// then N output beats. The run time of a request is dominated by the
// backtracking search. A new board size is taken while the last result
// still waits.
// Reset (synchronous, active low) returns to idle and drops o_valid.
// A stalled receiver holds the output register and pauses emission.
// ----------------------------------------------------------------------------
module n_queens_first_solution
    import nqf_pkg::*;
#(
    parameter int unsigned MAX_SIZE = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [SIZE_W-1:0]   i_board_size,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [FIELD_W-1:0]       o_row_index,
    output logic [FIELD_W-1:0]       o_queen_column,
    output logic                     o_last
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: search, sweep, emit or report
    nqf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // Stack, masks, result table and output register
    nqf_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_board_size   (i_board_size),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_row_index    (o_row_index),
        .o_queen_column (o_queen_column),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

### sv/nqf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nqf_ctrl
// Sequencer for the backtracking search, the table sweep and result output.
// ----------------------------------------------------------------------------
module nqf_ctrl
    import nqf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.code = RES_SOLUTION;
        o_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_stat.size_bad) begin
                    n_state = ST_REPORT_BAD;
                end else if (i_stat.col_done) begin
                    n_state = ST_SWEEP;
                end else if (i_stat.r_lt_n) begin
                    if (i_stat.sq_free) begin
                        o_cmd.place = 1'b1;
                    end else begin
                        o_cmd.next_row = 1'b1;
                    end
                end else if (i_stat.col_zero) begin
                    n_state = ST_REPORT_NONE;
                end else begin
                    o_cmd.pop = 1'b1;
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.row_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.row_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_REPORT_NONE: begin
                o_cmd.code = RES_NONE;
                if (i_stat.out_free) begin
                    o_cmd.report = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_REPORT_BAD: begin
                o_cmd.code = RES_INVALID;
                if (i_stat.out_free) begin
                    o_cmd.report = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### sv/nqf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nqf_dp
// Search datapath: row stack, occupancy masks, row scan, result table and
// the output register.
// ----------------------------------------------------------------------------
module nqf_dp
    import nqf_pkg::*;
#(
    parameter int unsigned MAX_SIZE = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [SIZE_W-1:0]   i_board_size,
    input  wire logic                i_stall,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [FIELD_W-1:0]       o_row_index,
    output logic [FIELD_W-1:0]       o_queen_column,
    output logic                     o_last
);

    localparam int unsigned CW  = $clog2(MAX_SIZE + 1);             // holds 0..MAX_SIZE
    localparam int unsigned RW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int unsigned DN  = 2 * MAX_SIZE - 1;                 // diagonals
    localparam int unsigned DW  = (DN > 1) ? $clog2(DN) : 1;
    localparam int unsigned XW  = (CW > SIZE_W) ? CW : SIZE_W;      // compare width
    localparam int unsigned SW  = XW + 1;                           // diagonal sums

    logic [SIZE_W-1:0]   r_n;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       r_row;
    logic [MAX_SIZE-1:0] r_rows;
    logic [DN-1:0]       r_down;
    logic [DN-1:0]       r_up;
    logic [RW-1:0]       r_roc [MAX_SIZE];   // row of each column
    logic [RW-1:0]       r_cor [MAX_SIZE];   // column of each row

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [FIELD_W-1:0]  r_out_row;
    logic [FIELD_W-1:0]  r_out_col;
    logic                r_out_last;

    logic [CW-1:0] col_m1;
    logic [RW-1:0] pop_row;
    logic [SW-1:0] d_cur;
    logic [SW-1:0] u_cur;
    logic [SW-1:0] d_pop;
    logic [SW-1:0] u_pop;
    logic [RW-1:0] row_i;
    logic [RW-1:0] col_i;
    logic [RW-1:0] pop_i;
    logic          out_free;
    logic          row_last;

    assign row_i   = r_row[RW-1:0];
    assign col_i   = r_col[RW-1:0];
    assign col_m1  = r_col - CW'(1);
    assign pop_i   = col_m1[RW-1:0];
    assign pop_row = r_roc[pop_i];

    // Diagonal indexes: down = r + n - 1 - c, up = r + c
    assign d_cur = SW'(r_row) + SW'(r_n) - SW'(1) - SW'(r_col);
    assign u_cur = SW'(r_row) + SW'(r_col);
    assign d_pop = SW'(pop_row) + SW'(r_n) - SW'(1) - SW'(col_m1);
    assign u_pop = SW'(pop_row) + SW'(col_m1);

    assign out_free = !r_out_valid || !i_stall;
    assign row_last = (XW'(r_row) + XW'(1)) == XW'(r_n);

    always_comb begin
        o_stat          = '0;
        o_stat.size_bad = (r_n == '0) || (XW'(r_n) > XW'(MAX_SIZE));
        o_stat.col_done = XW'(r_col) == XW'(r_n);
        o_stat.col_zero = (r_col == '0);
        o_stat.r_lt_n   = XW'(r_row) < XW'(r_n);
        o_stat.sq_free  = !r_rows[row_i] && !r_down[d_cur[DW-1:0]]
                          && !r_up[u_cur[DW-1:0]];
        o_stat.row_last = row_last;
        o_stat.out_free = out_free;
    end

    // Search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_rows <= '0;
            r_down <= '0;
            r_up   <= '0;
        end else if (i_cmd.start) begin
            r_n    <= i_board_size;
            r_col  <= '0;
            r_row  <= '0;
            r_rows <= '0;
            r_down <= '0;
            r_up   <= '0;
        end else if (i_cmd.place) begin
            r_rows[row_i]          <= ~r_rows[row_i];
            r_down[d_cur[DW-1:0]]  <= ~r_down[d_cur[DW-1:0]];
            r_up[u_cur[DW-1:0]]    <= ~r_up[u_cur[DW-1:0]];
            r_col                  <= r_col + CW'(1);
            r_row                  <= '0;
        end else if (i_cmd.next_row) begin
            r_row <= r_row + CW'(1);
        end else if (i_cmd.pop) begin
            r_rows[pop_row]        <= ~r_rows[pop_row];
            r_down[d_pop[DW-1:0]]  <= ~r_down[d_pop[DW-1:0]];
            r_up[u_pop[DW-1:0]]    <= ~r_up[u_pop[DW-1:0]];
            r_col                  <= col_m1;
            r_row                  <= CW'(pop_row) + CW'(1);
        end else if (i_cmd.sweep || i_cmd.emit) begin
            // wrap to row zero after the last one
            r_row <= row_last ? '0 : r_row + CW'(1);
        end
    end

    // Row stack and inverted table; no reset, every read entry is written first
    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_roc[col_i] <= row_i;
        end
        if (i_cmd.sweep) begin
            r_cor[r_roc[row_i]] <= row_i;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.report) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= RES_SOLUTION;
            r_out_row    <= FIELD_W'(r_row);
            r_out_col    <= FIELD_W'(r_cor[row_i]);
            r_out_last   <= row_last;
        end else if (i_cmd.report) begin
            r_out_status <= i_cmd.code;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_row_index    = r_out_row;
    assign o_queen_column = r_out_col;
    assign o_last         = r_out_last;

endmodule
`default_nettype wire
